@@ hdl/mpcb_pkg.sv @@
// Shared types and constants for the masked planar-to-chunky blit unit.
package mpcb_pkg;

    localparam int PLANES      = 4;
    localparam int LANES       = 8;
    localparam int OUT_ADDR_W  = 18;
    localparam int COUNT_W     = 10;
    localparam int STRIDE_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEST_BASE   = 3'd0,
        REG_ROW_BYTES   = 3'd1,
        REG_ROWS        = 3'd2,
        REG_LINE_STRIDE = 3'd3,
        REG_USE_MASK    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] dest_base;
        logic [COUNT_W-1:0]    row_bytes;
        logic [COUNT_W-1:0]    rows;
        logic [STRIDE_W-1:0]   line_stride;
        logic                  use_mask;
    } cfg_t;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] pixel_address;
        logic                  block_done;
    } loc_t;

endpackage

@@ hdl/mpcb_lane.sv @@
// One pixel lane: gathers one bit from each plane into a nibble and forms its write enable.
module mpcb_lane
    import mpcb_pkg::*;
(
    input  logic [PLANES-1:0] plane_bits,
    input  logic              mask_bit,
    input  logic              use_mask,
    output logic [PLANES-1:0] nibble,
    output logic              enable
);

    assign nibble = plane_bits;
    // A set mask bit keeps the old pixel, but only while masking is on.
    assign enable = ~(use_mask & mask_bit);

endmodule

@@ hdl/mpcb_addr_gen.sv @@
// Column and row counters that walk the rectangle and produce each item's address.
module mpcb_addr_gen
    import mpcb_pkg::*;
#(
    parameter int ADDR_W = 18
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic step,
    output loc_t loc
);

    logic [COUNT_W-1:0] column_reg, column_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0]  row_start_reg, row_start_next;

    logic [COUNT_W-1:0] width, height, column_inc, row_inc;
    logic [ADDR_W-1:0]  row_start, addr;
    logic               end_row, end_block;

    always_comb
    begin
        width  = (cfg.row_bytes == '0) ? COUNT_W'(1) : cfg.row_bytes;
        height = (cfg.rows == '0) ? COUNT_W'(1) : cfg.rows;
        // A new block latches the base address on its first item.
        row_start = (column_reg == '0 && row_reg == '0) ? ADDR_W'(cfg.dest_base)
                                                          : row_start_reg;
        // The memory size is a power of two, so wrapping is truncation.
        addr = row_start + ADDR_W'({column_reg, 3'b000});

        column_inc = column_reg + COUNT_W'(1);
        row_inc    = row_reg + COUNT_W'(1);
        end_row    = (column_inc == '0) || (column_inc >= width);
        end_block  = end_row && ((row_inc == '0) || (row_inc >= height));

        column_next    = column_reg;
        row_next       = row_reg;
        row_start_next = row_start_reg;
        if (step)
        begin
            row_start_next = row_start;
            column_next    = column_inc;
            if (end_row)
            begin
                column_next    = '0;
                row_next       = end_block ? '0 : row_inc;
                row_start_next = row_start + ADDR_W'(cfg.line_stride);
            end
        end

        loc.pixel_address = OUT_ADDR_W'(addr);
        loc.block_done    = end_block;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            row_start_reg <= '0;
        end
        else
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            row_start_reg <= row_start_next;
        end
    end

endmodule

@@ hdl/masked_planar_to_chunky_blit_unit.sv @@
// Top level of the masked planar-to-chunky blit unit: config registers, lanes and output stage.
//
//  Channel   Direction  Transfer when           Payload
//  s_*       in         s_tvalid & s_tready     tdata: plane0..plane3, mask (8 bits each)
//  m_*       out        m_tvalid & m_tready     tdata: address, pixels, enables; tlast: done
//  cfg_*     in         cfg_valid & cfg_ready   cfg_index selects register, cfg_data value
//
// One item per cycle while not stalled; each result appears in the cycle after its input.
// Eight pixel lanes work in parallel and a single output register holds the result.
// s_tready is low only while a result waits and m_tready is low; cfg_ready is always high.
// Reset clears configuration, counters and the output valid flag.
// MEM_SIZE must be a power of two; addresses wrap by truncation.
module masked_planar_to_chunky_blit_unit
    import mpcb_pkg::*;
#(
    parameter int MEM_SIZE = 262144
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] plane0_bits, [15:8] plane1_bits, [23:16] plane2_bits,
    // [31:24] plane3_bits, [39:32] mask_bits
    input  logic [S_DATA_W-1:0]    s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [17:0] pixel_address, [49:18] pixels, [57:50] write_enable, [63:58] zero
    output logic [M_DATA_W-1:0]    m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MEM_SIZE);

    cfg_t cfg_reg, cfg_next;
    loc_t loc;
    logic accept;

    logic [LANES*PLANES-1:0] pixels;
    logic [LANES-1:0]        enables;

    logic                  valid_reg, valid_next;
    logic [M_DATA_W-1:0]   data_reg;
    logic                  last_reg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEST_BASE:   cfg_next.dest_base   = cfg_data;
                REG_ROW_BYTES:   cfg_next.row_bytes   = cfg_data[COUNT_W-1:0];
                REG_ROWS:        cfg_next.rows        = cfg_data[COUNT_W-1:0];
                REG_LINE_STRIDE: cfg_next.line_stride = cfg_data[STRIDE_W-1:0];
                REG_USE_MASK:    cfg_next.use_mask    = cfg_data[0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    mpcb_addr_gen #(
        .ADDR_W (ADDR_W)
    ) u_addr_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (accept),
        .loc   (loc)
    );

    // Lane b takes bit b of every plane; bit 7 is the leftmost pixel.
    for (genvar b = 0; b < LANES; b++)
    begin : g_lane
        mpcb_lane u_lane (
            .plane_bits ({s_tdata[3*LANES+b], s_tdata[2*LANES+b],
                          s_tdata[LANES+b], s_tdata[b]}),
            .mask_bit   (s_tdata[PLANES*LANES+b]),
            .use_mask   (cfg_reg.use_mask),
            .nibble     (pixels[PLANES*b +: PLANES]),
            .enable     (enables[b])
        );
    end

    assign valid_next = accept || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= {6'b0, enables, pixels, loc.pixel_address};
            last_reg <= loc.block_done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ hdl/mpcb_checker.sv @@
// Port-level checker for the blit unit and the bind that attaches it.
module mpcb_checker
    import mpcb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_DATA_W-1:0]    s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_W-1:0]    m_tdata,
    input logic                   m_tlast
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Input is blocked only by a waiting, untaken result.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stage");

    // Every input transfer yields a result on the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("result missing after input transfer");

    // The rightmost pixel gathers bit 0 of each plane.
    a_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tdata[21:18] ==
            {$past(s_tdata[24]), $past(s_tdata[16]), $past(s_tdata[8]), $past(s_tdata[0])})
        else $error("rightmost pixel mismatch");

    // Padding above the write enables is zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:58] == 6'b0)
        else $error("nonzero padding in result");

endmodule

bind masked_planar_to_chunky_blit_unit mpcb_checker u_mpcb_checker (.*);

@@ test/masked_planar_to_chunky_blit_unit_tb.sv @@
// Self-checking testbench for the masked planar-to-chunky blit unit.
module masked_planar_to_chunky_blit_unit_tb
    import mpcb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 700;

    typedef struct {
        logic [OUT_ADDR_W-1:0] addr;
        logic [31:0]           pixels;
        logic [LANES-1:0]      write_en;
        logic                  done;
    } chunky_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: register copy plus the rectangle walk.
    cfg_t                  blit_cfg;
    logic [COUNT_W-1:0]    column_pos;
    logic [COUNT_W-1:0]    row_pos;
    logic [OUT_ADDR_W-1:0] row_base;

    chunky_write_t pending_writes[$];
    chunky_write_t want;

    int  fail_count;
    int  items_sent;
    int  reg_writes;
    int  writes_checked;
    int  blocks_done;
    int  cycle_count;
    int  hold_cycles;
    bit  no_idle;

    masked_planar_to_chunky_blit_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch in %s: got %h, expected %h", field, got, exp_val);
        fail_count++;
    endtask

    // Works out the screen write for one accepted plane group and advances the walk.
    function automatic void predict_chunky_write(input logic [S_DATA_W-1:0] d);
        chunky_write_t w;
        int width;
        int height;
        width  = (blit_cfg.row_bytes == 0) ? 1 : int'(blit_cfg.row_bytes);
        height = (blit_cfg.rows == 0) ? 1 : int'(blit_cfg.rows);
        if (column_pos == 0 && row_pos == 0)
            row_base = blit_cfg.dest_base;
        w.addr = row_base + (OUT_ADDR_W'(column_pos) << 3);
        for (int b = 0; b < LANES; b++)
            w.pixels[4*b +: 4] = {d[24+b], d[16+b], d[8+b], d[b]};
        w.write_en = blit_cfg.use_mask ? ~d[39:32] : 8'hFF;
        w.done = 1'b0;
        column_pos = column_pos + 1'b1;
        if (column_pos == 0 || int'(column_pos) >= width)
        begin
            column_pos = '0;
            row_pos    = row_pos + 1'b1;
            row_base   = row_base + OUT_ADDR_W'(blit_cfg.line_stride);
            if (row_pos == 0 || int'(row_pos) >= height)
            begin
                row_pos = '0;
                w.done  = 1'b1;
            end
        end
        pending_writes.push_back(w);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [S_DATA_W-1:0] random_item();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {8'($urandom()), 32'($urandom())};
        endcase
    endfunction

    // Leaves s_tvalid high after the transfer so back-to-back items need no gap.
    task automatic send_item(input logic [S_DATA_W-1:0] d);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        predict_chunky_write(d);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEST_BASE:   blit_cfg.dest_base   = value;
            REG_ROW_BYTES:   blit_cfg.row_bytes   = value[COUNT_W-1:0];
            REG_ROWS:        blit_cfg.rows        = value[COUNT_W-1:0];
            REG_LINE_STRIDE: blit_cfg.line_stride = value[STRIDE_W-1:0];
            REG_USE_MASK:    blit_cfg.use_mask    = value[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers at reset give a one-item rectangle with masking off.
    task automatic test_zero_sizes();
        send_item('0);
        send_item('1);
        send_item(40'hFF_0F_33_55_AA);
        for (int k = 0; k < PLANES; k++)
            send_item(40'hFF_00_00_00_81 << (8 * k));
        send_item({8'hA5, 32'($urandom())});
        drain_results();
    endtask

    // Masking on, base at the top of memory and the widest stride, so addresses wrap around.
    task automatic test_mask_and_wrap();
        logic [7:0] masks[7] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h5A, 8'hA5, 8'h81};
        write_reg(REG_DEST_BASE, 18'h3FFFF);
        write_reg(REG_ROW_BYTES, 18'd2);
        write_reg(REG_ROWS, 18'd3);
        write_reg(REG_LINE_STRIDE, 18'hFFFF);
        write_reg(REG_USE_MASK, 18'd1);
        foreach (masks[i])
            send_item({masks[i], 32'($urandom())});
        drain_results();
    endtask

    // Shrinking the rectangle below the current position ends the row, then the block.
    task automatic test_mid_block_config();
        write_reg(REG_DEST_BASE, 18'd0);
        write_reg(REG_ROW_BYTES, 18'd1023);
        write_reg(REG_ROWS, 18'd1023);
        repeat (3) send_item(random_item());
        drain_results();
        write_reg(REG_ROW_BYTES, 18'd1);
        send_item(random_item());
        drain_results();
        write_reg(REG_ROWS, 18'd1);
        send_item(random_item());
        drain_results();
        write_reg(REG_USE_MASK, 18'd0);
        send_item({8'hFF, 32'($urandom())});
        drain_results();
    endtask

    // The receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        write_reg(REG_ROW_BYTES, 18'd3);
        write_reg(REG_ROWS, 18'd2);
        no_idle     = 1'b1;
        hold_cycles = 60;
        repeat (20) send_item(random_item());
        drain_results();
        no_idle = 1'b0;
    endtask

    task automatic test_random_blits();
        int target;
        int phase_items;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_DEST_BASE, ($urandom_range(0, 4) == 0) ?
                          (($urandom_range(0, 1) == 0) ? 18'h0 : 18'h3FFFF) : 18'($urandom()));
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_ROW_BYTES, ($urandom_range(0, 19) == 0) ? 18'd1023 :
                          18'($urandom_range(0, 6)));
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_ROWS, ($urandom_range(0, 29) == 0) ? 18'd1023 :
                          18'($urandom_range(0, 4)));
            if ($urandom_range(0, 9) < 5)
                write_reg(REG_LINE_STRIDE, ($urandom_range(0, 5) == 0) ? 18'hFFFF :
                          18'($urandom_range(0, 65535)));
            if ($urandom_range(0, 9) < 5)
                write_reg(REG_USE_MASK, 18'($urandom_range(0, 1)));
            no_idle     = ($urandom_range(0, 5) == 0);
            phase_items = $urandom_range(10, 40);
            repeat (phase_items) send_item(random_item());
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    // Output ready: random runs of high and low, a long hold-off on request.
    initial
    begin
        int run_left;
        bit level;
        run_left = 0;
        level    = 1'b1;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (no_idle)
                m_tready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(0, 19)) inside
                        0: begin level = 1'b0; run_left = $urandom_range(10, 40); end
                        [1:5]: begin level = 1'b0; run_left = $urandom_range(1, 3); end
                        default: begin level = 1'b1; run_left = $urandom_range(1, 8); end
                    endcase
                end
                run_left--;
                m_tready <= level;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
                report_mismatch("result with nothing pending", m_tdata[31:0], '0);
            else
            begin
                want = pending_writes.pop_front();
                if (m_tdata[17:0] !== want.addr)
                    report_mismatch("pixel_address", 32'(m_tdata[17:0]), 32'(want.addr));
                if (m_tdata[49:18] !== want.pixels)
                    report_mismatch("pixels", m_tdata[49:18], want.pixels);
                if (m_tdata[57:50] !== want.write_en)
                    report_mismatch("write_enable", 32'(m_tdata[57:50]), 32'(want.write_en));
                if (m_tlast !== want.done)
                    report_mismatch("block_done", 32'(m_tlast), 32'(want.done));
                writes_checked++;
                if (want.done)
                    blocks_done++;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_DEST_BASE;
        cfg_data       = '0;
        blit_cfg       = '0;
        column_pos     = '0;
        row_pos        = '0;
        row_base       = '0;
        fail_count     = 0;
        items_sent     = 0;
        reg_writes     = 0;
        writes_checked = 0;
        blocks_done    = 0;
        cycle_count    = 0;
        hold_cycles    = 0;
        no_idle        = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_sizes();
        test_mask_and_wrap();
        test_mid_block_config();
        test_backpressure();
        test_random_blits();

        drain_results();
        repeat (10) @(posedge clk);
        if (pending_writes.size() != 0)
            report_mismatch("writes still pending", pending_writes.size(), 0);
        $display("sent %0d plane groups over %0d register writes", items_sent, reg_writes);
        $display("checked %0d screen writes, %0d rectangles completed, %0d mismatches",
                 writes_checked, blocks_done, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ masked_planar_to_chunky_blit_unit.f @@
hdl/mpcb_pkg.sv
hdl/mpcb_lane.sv
hdl/mpcb_addr_gen.sv
hdl/masked_planar_to_chunky_blit_unit.sv
hdl/mpcb_checker.sv
test/masked_planar_to_chunky_blit_unit_tb.sv
